// File: sv/dls_pkg.sv
// shared types and constants for the dense list store
// no dependencies
package dls_pkg;

	localparam int DLS_CAPACITY    = 256;
	localparam int DLS_VALUE_WIDTH = 64;

	// field widths of the request and the result
	localparam int ACTION_W   = 3;
	localparam int INDEX_W    = 8;
	localparam int VALUE_W    = 64;
	localparam int STATUS_W   = 2;
	localparam int COUNT_W    = 9;
	localparam int IN_TDATA_W  = 80;
	localparam int OUT_TDATA_W = 80;

	typedef enum logic [ACTION_W-1:0] {
		ACT_APPEND = 3'd0,
		ACT_STORE  = 3'd1,
		ACT_READ   = 3'd2,
		ACT_DELETE = 3'd3,
		ACT_CHECK  = 3'd4
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_FULL      = 2'd1,
		STAT_BAD_INDEX = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_READ  = 2'd1,
		ST_SHIFT = 2'd2,
		ST_DONE  = 2'd3
	} state_t;

endpackage

// File: sv/dls_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module dls_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: sv/dense_list_store_with_shift_delete.sv
// dense list store: list of value words in a ram with a count and shift delete
// depends on dls_pkg and dls_ram
//
// The block keeps a dense list of up to CAPACITY value words in one
// synchronous ram plus an element count held in flip-flops. Each request
// carries one action: append, store, read, delete or check, and gives
// exactly one result with the read value, an index-valid flag (index below
// the count held before the request), a status and the count after the
// request. Requests are taken one at a time. Append, store and check go
// from acceptance straight to the done state, read passes a read state
// first because of the registered ram read. Delete moves every later
// entry down by one place through the single ram, one entry per cycle
// with reads and writes overlapped. A finished result sits in an output
// register, and the next request is accepted while it waits to be taken.
// Entries past the count are never read, so the ram needs no clearing
// after reset.
module dense_list_store_with_shift_delete
	import dls_pkg::*;
#(
	parameter int CAPACITY    = DLS_CAPACITY,
	parameter int VALUE_WIDTH = DLS_VALUE_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// request stream
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// action [2:0], index [10:3], value [74:11], zeros [79:75]
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// result stream
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// read_value [63:0], index_ok [64], status [66:65],
	// element_count [75:67], zeros [79:76]
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	localparam int ADDR_W = $clog2(CAPACITY);
	localparam int CNT_W  = $clog2(CAPACITY + 1);
	// compare width, wide enough for the count, the index and the result count
	localparam int CMP_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

	// request fields
	logic [ACTION_W-1:0] in_action;
	logic [INDEX_W-1:0]  in_index;
	logic [VALUE_W-1:0]  in_value;

	assign in_action = s_tdata[ACTION_W-1:0];
	assign in_index  = s_tdata[ACTION_W +: INDEX_W];
	assign in_value  = s_tdata[ACTION_W + INDEX_W +: VALUE_W];

	// control state
	state_t           state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic             m_valid_q, m_valid_d;

	// payload registers
	logic [ADDR_W-1:0]      ptr_q, ptr_d;
	logic                   ok_q, ok_d;
	status_t                status_q, status_d;
	logic [VALUE_WIDTH-1:0] rd_q, rd_d;
	logic [OUT_TDATA_W-1:0] m_data_q, m_data_d;

	// ram port
	logic                   ram_we;
	logic [ADDR_W-1:0]      ram_waddr;
	logic [VALUE_WIDTH-1:0] ram_wdata;
	logic [ADDR_W-1:0]      ram_raddr;
	logic [VALUE_WIDTH-1:0] ram_rdata;

	// widened views for compares
	logic [CMP_W-1:0] idx_ext, cnt_ext, idx_next, ptr_plus2;
	logic             in_ok, accept, out_free;

	assign idx_ext   = CMP_W'(in_index);
	assign cnt_ext   = CMP_W'(count_q);
	assign idx_next  = idx_ext + CMP_W'(1);
	assign ptr_plus2 = CMP_W'(ptr_q) + CMP_W'(2);
	assign in_ok     = idx_ext < cnt_ext;
	assign accept    = s_tvalid && s_tready;
	// the output register can take a new result this cycle
	assign out_free  = !m_valid_q || m_tready;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	dls_ram #(
		.WIDTH (VALUE_WIDTH),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		ptr_d     = ptr_q;
		ok_d      = ok_q;
		status_d  = status_q;
		rd_d      = rd_q;
		m_data_d  = m_data_q;
		m_valid_d = m_valid_q && !m_tready;
		ram_we    = 1'b0;
		ram_waddr = ptr_q;
		ram_wdata = ram_rdata;
		ram_raddr = idx_ext[ADDR_W-1:0];

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					ok_d     = in_ok;
					status_d = STAT_OK;
					rd_d     = '0;
					state_d  = ST_DONE;
					case (action_t'(in_action))
						ACT_APPEND: begin
							if (cnt_ext >= CMP_W'(CAPACITY)) begin
								status_d = STAT_FULL;
							end else begin
								ram_we    = 1'b1;
								ram_waddr = count_q[ADDR_W-1:0];
								ram_wdata = in_value[VALUE_WIDTH-1:0];
								count_d   = count_q + CNT_W'(1);
							end
						end
						ACT_STORE: begin
							if (in_ok) begin
								ram_we    = 1'b1;
								ram_waddr = idx_ext[ADDR_W-1:0];
								ram_wdata = in_value[VALUE_WIDTH-1:0];
							end else begin
								status_d = STAT_BAD_INDEX;
							end
						end
						ACT_READ: begin
							if (in_ok) begin
								ram_raddr = idx_ext[ADDR_W-1:0];
								state_d   = ST_READ;
							end else begin
								status_d = STAT_BAD_INDEX;
							end
						end
						ACT_DELETE: begin
							if (!in_ok) begin
								status_d = STAT_BAD_INDEX;
							end else if (idx_next < cnt_ext) begin
								// fetch the first entry to move down
								ram_raddr = idx_next[ADDR_W-1:0];
								ptr_d     = idx_ext[ADDR_W-1:0];
								state_d   = ST_SHIFT;
							end else begin
								// last entry removed, nothing to move
								count_d = count_q - CNT_W'(1);
							end
						end
						default: begin
							// check and unused actions change nothing
						end
					endcase
				end
			end
			ST_READ: begin
				rd_d    = ram_rdata;
				state_d = ST_DONE;
			end
			ST_SHIFT: begin
				// write the entry fetched last cycle one place down,
				// fetch the one after it in the same cycle
				ram_we    = 1'b1;
				ram_waddr = ptr_q;
				ram_wdata = ram_rdata;
				ptr_d     = ptr_q + ADDR_W'(1);
				if (ptr_plus2 < cnt_ext) begin
					ram_raddr = ptr_plus2[ADDR_W-1:0];
				end else begin
					count_d = count_q - CNT_W'(1);
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					m_data_d  = '0;
					m_data_d[VALUE_W-1:0] = VALUE_W'(rd_q);
					m_data_d[VALUE_W]     = ok_q;
					m_data_d[VALUE_W + 1 +: STATUS_W] = status_q;
					m_data_d[VALUE_W + 1 + STATUS_W +: COUNT_W] =
						cnt_ext[COUNT_W-1:0];
					m_valid_d = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			count_q   <= count_d;
			m_valid_q <= m_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		ptr_q    <= ptr_d;
		ok_q     <= ok_d;
		status_q <= status_d;
		rd_q     <= rd_d;
		m_data_q <= m_data_d;
	end

endmodule
